@@ rtl/core/prltv_pkg.sv @@
// Package for the paired read library type voter.
// Holds the format, orientation and strand codes, counter widths and the
// structs passed between the tally and decision stages. No dependencies.
package prltv_pkg;

    // Width of every vote counter.
    localparam int CW = 32;
    // Width of the reported vote total and the internal clamp width.
    localparam int VOTE_W = 32;
    localparam int WIDE_W = (CW > VOTE_W) ? CW : VOTE_W;
    // Percent thresholds are 7-bit values.
    localparam int PCT_W = 7;
    // Width of a percent product: a percent times the sum of four counters.
    localparam int PROD_W = CW + 2 + PCT_W;
    localparam int START_W = 31;
    localparam int MATE_W = 2;
    localparam int NUM_VOTED = 4;

    localparam logic [START_W-1:0] LEFT_INIT = '1;
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [PCT_W-1:0] RESET_REVERSE_PCT = 7'd30;
    localparam logic [PCT_W-1:0] RESET_UNSTRANDED_PCT = 7'd70;
    localparam logic [PCT_W-1:0] RESET_WEAK_PCT = 7'd85;

    localparam logic [MATE_W-1:0] MATE_FIRST = 2'd0;
    localparam logic [MATE_W-1:0] MATE_SECOND = 2'd1;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_ISF  = 3'd1,
        FMT_ISR  = 3'd2,
        FMT_OSF  = 3'd3,
        FMT_OSR  = 3'd4,
        FMT_MSF  = 3'd5,
        FMT_MSR  = 3'd6,
        FMT_IU   = 3'd7
    } t_format;

    typedef enum logic [1:0] {
        ORIENT_INWARD  = 2'd0,
        ORIENT_OUTWARD = 2'd1,
        ORIENT_SAME    = 2'd2
    } t_orient;

    typedef enum logic [1:0] {
        STRAND_UNSTRANDED = 2'd0,
        STRAND_FORWARD    = 2'd1,
        STRAND_REVERSE    = 2'd2
    } t_strand;

    typedef enum logic [1:0] {
        CFG_REVERSE_PCT    = 2'd0,
        CFG_UNSTRANDED_PCT = 2'd1,
        CFG_WEAK_PCT       = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [PCT_W-1:0] reverse_pct;
        logic [PCT_W-1:0] unstranded_pct;
        logic [PCT_W-1:0] weak_pct;
    } t_thresholds;

    // Counter snapshot taken right after one alignment's vote.
    typedef struct packed {
        t_format       voted;
        logic [CW-1:0] cnt_isf;
        logic [CW-1:0] cnt_isr;
        logic [CW-1:0] cnt_osf;
        logic [CW-1:0] cnt_osr;
        logic [CW-1:0] total;
    } t_tally;

    typedef struct packed {
        t_format           voted;
        t_orient           orient;
        t_strand           strand;
        t_format           winner;
        logic [VOTE_W-1:0] vote_total;
        logic              no_votes;
        logic              weak_winner;
        logic              winner_not_inward;
    } t_result;

endpackage

@@ rtl/core/paired_read_library_type_voter.sv @@
// Top level of the paired read library type voter.
// Depends on prltv_pkg, prltv_tally and prltv_decide.
//
// Usage:
// Exons of paired-end alignments arrive one request at a time on the input
// channel (i_valid / o_ready). Each exon updates the leftmost start of its
// mate; mate indices 2 and 3 are ignored. The exon marked last closes the
// alignment: a paired alignment with both mates seen is classified as ISF,
// ISR, OSF or OSR and voted, and one result request leaves on the output
// channel (o_valid / i_ready) with the running library type decision.
// Exons that are not last produce no result.
// Throughput: one exon per cycle while the result channel is not stalled,
// including back-to-back last exons. A last exon passes six registers
// (input register, tally, three decision stages, result register) on its
// way to o_valid. The percent compares use small multipliers by the 7-bit
// thresholds that sit in their own stage, ahead of the final compares.
// Stalls: every stage holds while the next one is full, so a waiting result
// does not stop new exons until the pipeline has filled behind it.
// Reset: synchronous, active low. Thresholds return to 30, 70 and 85
// percent, all vote counters clear and the current alignment is dropped.
// The user must write thresholds through the plain write port only while idle; the block does not enforce this.
// The exon length is accepted with each request but has no effect.
module paired_read_library_type_voter
    import prltv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [PCT_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [MATE_W-1:0]  i_mate_index,
    input  logic [START_W-1:0] i_exon_start,
    input  logic [15:0]        i_exon_length,
    input  logic               i_strand_label,
    input  logic               i_is_paired,
    input  logic               i_last_exon,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_voted_format,
    output logic [1:0]         o_pair_orientation,
    output logic [1:0]         o_strand_call,
    output logic [2:0]         o_winner_format,
    output logic [VOTE_W-1:0]  o_vote_total,
    output logic               o_no_votes,
    output logic               o_weak_winner,
    output logic               o_winner_not_inward
);

    t_thresholds r_thr;
    logic        tally_valid;
    logic        tally_ready;
    t_tally      tally;
    t_result     result;

    // Threshold registers. Writes to an index past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.reverse_pct    <= RESET_REVERSE_PCT;
            r_thr.unstranded_pct <= RESET_UNSTRANDED_PCT;
            r_thr.weak_pct       <= RESET_WEAK_PCT;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REVERSE_PCT:    r_thr.reverse_pct    <= i_cfg_wdata;
                CFG_UNSTRANDED_PCT: r_thr.unstranded_pct <= i_cfg_wdata;
                CFG_WEAK_PCT:       r_thr.weak_pct       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Mate tracking, classification and vote counters.
    prltv_tally u_tally (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mate_index   (i_mate_index),
        .i_exon_start   (i_exon_start),
        .i_strand_label (i_strand_label),
        .i_is_paired    (i_is_paired),
        .i_last_exon    (i_last_exon),
        .o_valid        (tally_valid),
        .i_ready        (tally_ready),
        .o_tally        (tally)
    );

    // Running decision from each counter snapshot.
    prltv_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_thr    (r_thr),
        .i_valid  (tally_valid),
        .o_ready  (tally_ready),
        .i_tally  (tally),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_voted_format      = result.voted;
    assign o_pair_orientation  = result.orient;
    assign o_strand_call       = result.strand;
    assign o_winner_format     = result.winner;
    assign o_vote_total        = result.vote_total;
    assign o_no_votes          = result.no_votes;
    assign o_weak_winner       = result.weak_winner;
    assign o_winner_not_inward = result.winner_not_inward;

endmodule

@@ rtl/core/prltv_tally.sv @@
// Exon input register, per-alignment mate tracking, pair classification and
// the saturating vote counters. Emits a counter snapshot per last exon.
// Depends on prltv_pkg.
module prltv_tally
    import prltv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [MATE_W-1:0]  i_mate_index,
    input  logic [START_W-1:0] i_exon_start,
    input  logic               i_strand_label,
    input  logic               i_is_paired,
    input  logic               i_last_exon,
    output logic               o_valid,
    input  logic               i_ready,
    output t_tally             o_tally
);

    typedef struct packed {
        logic [MATE_W-1:0]  mate;
        logic [START_W-1:0] start;
        logic               strand;
        logic               paired;
        logic               last;
    } t_exon;

    logic               r_v0;
    t_exon              r_in;
    logic               r_v1;
    t_tally             r_tally;

    logic               r_seen1;
    logic               r_seen2;
    logic [START_W-1:0] r_left1;
    logic [START_W-1:0] r_left2;
    logic [CW-1:0]      r_cnt [NUM_VOTED];
    logic [CW-1:0]      r_total;

    logic               n_seen1;
    logic               n_seen2;
    logic [START_W-1:0] n_left1;
    logic [START_W-1:0] n_left2;
    logic [CW-1:0]      n_cnt [NUM_VOTED];
    logic [CW-1:0]      n_total;
    t_format            voted;
    logic               leave;

    // A non-last exon only touches mate state, so it never waits on the snapshot stage.
    assign leave   = r_v0 && (!r_in.last || !r_v1 || i_ready);
    assign o_ready = !r_v0 || leave;
    assign o_valid = r_v1;
    assign o_tally = r_tally;

    always_comb begin
        n_seen1 = r_seen1;
        n_seen2 = r_seen2;
        n_left1 = r_left1;
        n_left2 = r_left2;
        if (r_in.mate == MATE_FIRST) begin
            n_seen1 = 1'b1;
            if (r_in.start < r_left1) begin
                n_left1 = r_in.start;
            end
        end else if (r_in.mate == MATE_SECOND) begin
            n_seen2 = 1'b1;
            if (r_in.start < r_left2) begin
                n_left2 = r_in.start;
            end
        end

        voted = FMT_NONE;
        if (r_in.paired && n_seen1 && n_seen2) begin
            if (!r_in.strand) begin
                voted = (n_left1 <= n_left2) ? FMT_ISF : FMT_OSF;
            end else begin
                voted = (n_left2 <= n_left1) ? FMT_ISR : FMT_OSR;
            end
        end

        for (int i = 0; i < NUM_VOTED; i++) begin
            n_cnt[i] = r_cnt[i];
            if (voted == t_format'(3'(i + 1)) && r_cnt[i] != '1) begin
                n_cnt[i] = r_cnt[i] + 1'b1;
            end
        end
        n_total = r_total;
        if (voted != FMT_NONE && r_total != '1) begin
            n_total = r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_seen1 <= 1'b0;
            r_seen2 <= 1'b0;
            r_left1 <= LEFT_INIT;
            r_left2 <= LEFT_INIT;
            r_total <= '0;
            for (int i = 0; i < NUM_VOTED; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_v0 <= i_valid;
            end
            // A new snapshot only loads once the old one is gone or leaving.
            if (leave && r_in.last) begin
                r_v1 <= 1'b1;
            end else if (i_ready) begin
                r_v1 <= 1'b0;
            end
            if (leave) begin
                if (r_in.last) begin
                    r_seen1 <= 1'b0;
                    r_seen2 <= 1'b0;
                    r_left1 <= LEFT_INIT;
                    r_left2 <= LEFT_INIT;
                    r_total <= n_total;
                    for (int i = 0; i < NUM_VOTED; i++) begin
                        r_cnt[i] <= n_cnt[i];
                    end
                end else begin
                    r_seen1 <= n_seen1;
                    r_seen2 <= n_seen2;
                    r_left1 <= n_left1;
                    r_left2 <= n_left2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.mate   <= i_mate_index;
            r_in.start  <= i_exon_start;
            r_in.strand <= i_strand_label;
            r_in.paired <= i_is_paired;
            r_in.last   <= i_last_exon;
        end
        if (leave && r_in.last) begin
            r_tally.voted   <= voted;
            r_tally.cnt_isf <= n_cnt[0];
            r_tally.cnt_isr <= n_cnt[1];
            r_tally.cnt_osf <= n_cnt[2];
            r_tally.cnt_osr <= n_cnt[3];
            r_tally.total   <= n_total;
        end
    end

    // Every vote also bumps the total, and both saturate at the same value.
    a_total_covers_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= r_total && r_cnt[1] <= r_total &&
        r_cnt[2] <= r_total && r_cnt[3] <= r_total)
        else $error("vote counter exceeds vote total");

    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) == (r_cnt[0] == '0 && r_cnt[1] == '0 &&
                            r_cnt[2] == '0 && r_cnt[3] == '0))
        else $error("vote total disagrees with counters");

    a_alignment_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        leave && r_in.last |=> !r_seen1 && !r_seen2 &&
        r_left1 == LEFT_INIT && r_left2 == LEFT_INIT)
        else $error("mate state not cleared after last exon");

endmodule

@@ rtl/core/prltv_decide.sv @@
// Decision pipeline: sums, winner search, percent products and the final
// compares on one counter snapshot, ending in the result register.
// Depends on prltv_pkg.
module prltv_decide
    import prltv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_thresholds i_thr,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_tally      i_tally,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    typedef struct packed {
        t_format       voted;
        logic [CW:0]   inw;
        logic [CW:0]   outw;
        logic [CW:0]   fwd;
        logic [CW:0]   rev;
        logic [CW-1:0] max_a;
        t_format       code_a;
        logic [CW-1:0] max_b;
        t_format       code_b;
        logic [CW-1:0] total;
    } t_sums;

    typedef struct packed {
        t_format       voted;
        t_orient       orient;
        logic [CW:0]   fwd;
        logic [CW+1:0] st;
        logic [CW-1:0] best;
        t_format       winner;
        logic [CW-1:0] total;
    } t_pick;

    typedef struct packed {
        t_format           voted;
        t_orient           orient;
        t_format           winner;
        logic [CW-1:0]     total;
        logic              st_zero;
        logic [PROD_W-1:0] p_fwd;
        logic [PROD_W-1:0] p_rev;
        logic [PROD_W-1:0] p_uns;
        logic [PROD_W-1:0] p_best;
        logic [PROD_W-1:0] p_weak;
    } t_prod;

    logic    r_v2, r_v3, r_v4, r_v5;
    t_sums   r_s2, n_s2;
    t_pick   r_s3, n_s3;
    t_prod   r_s4, n_s4;
    t_result r_s5, n_s5;
    logic    rdy2, rdy3, rdy4, rdy5;
    logic [WIDE_W-1:0] total_wide;

    assign rdy5     = !r_v5 || i_ready;
    assign rdy4     = !r_v4 || rdy5;
    assign rdy3     = !r_v3 || rdy4;
    assign rdy2     = !r_v2 || rdy3;
    assign o_ready  = rdy2;
    assign o_valid  = r_v5;
    assign o_result = r_s5;

    always_comb begin
        n_s2.voted  = i_tally.voted;
        n_s2.inw    = (CW+1)'(i_tally.cnt_isf) + (CW+1)'(i_tally.cnt_isr);
        n_s2.outw   = (CW+1)'(i_tally.cnt_osf) + (CW+1)'(i_tally.cnt_osr);
        n_s2.fwd    = (CW+1)'(i_tally.cnt_isf) + (CW+1)'(i_tally.cnt_osf);
        n_s2.rev    = (CW+1)'(i_tally.cnt_isr) + (CW+1)'(i_tally.cnt_osr);
        // Ties keep the lower code.
        if (i_tally.cnt_isr > i_tally.cnt_isf) begin
            n_s2.max_a  = i_tally.cnt_isr;
            n_s2.code_a = FMT_ISR;
        end else begin
            n_s2.max_a  = i_tally.cnt_isf;
            n_s2.code_a = FMT_ISF;
        end
        if (i_tally.cnt_osr > i_tally.cnt_osf) begin
            n_s2.max_b  = i_tally.cnt_osr;
            n_s2.code_b = FMT_OSR;
        end else begin
            n_s2.max_b  = i_tally.cnt_osf;
            n_s2.code_b = FMT_OSF;
        end
        n_s2.total = i_tally.total;
    end

    // Same-direction and unstranded formats never collect votes, so the
    // same-direction orientation sum is always zero.
    always_comb begin
        n_s3.voted  = r_s2.voted;
        n_s3.orient = (r_s2.inw >= r_s2.outw) ? ORIENT_INWARD : ORIENT_OUTWARD;
        n_s3.fwd    = r_s2.fwd;
        n_s3.st     = (CW+2)'(r_s2.fwd) + (CW+2)'(r_s2.rev);
        if (r_s2.max_b > r_s2.max_a) begin
            n_s3.best   = r_s2.max_b;
            n_s3.winner = r_s2.code_b;
        end else begin
            n_s3.best   = r_s2.max_a;
            n_s3.winner = r_s2.code_a;
        end
        if (n_s3.best == '0) begin
            n_s3.winner = FMT_NONE;
        end
        n_s3.total = r_s2.total;
    end

    always_comb begin
        n_s4.voted   = r_s3.voted;
        n_s4.orient  = r_s3.orient;
        n_s4.winner  = r_s3.winner;
        n_s4.total   = r_s3.total;
        n_s4.st_zero = (r_s3.st == '0);
        n_s4.p_fwd   = PROD_W'(r_s3.fwd) * PROD_W'(PCT_SCALE);
        n_s4.p_rev   = PROD_W'(i_thr.reverse_pct) * PROD_W'(r_s3.st);
        n_s4.p_uns   = PROD_W'(i_thr.unstranded_pct) * PROD_W'(r_s3.st);
        n_s4.p_best  = PROD_W'(r_s3.best) * PROD_W'(PCT_SCALE);
        n_s4.p_weak  = PROD_W'(i_thr.weak_pct) * PROD_W'(r_s3.total);
    end

    always_comb begin
        total_wide       = WIDE_W'(r_s4.total);
        n_s5.voted       = r_s4.voted;
        n_s5.orient      = r_s4.orient;
        n_s5.winner      = r_s4.winner;
        n_s5.no_votes    = (r_s4.total == '0);
        n_s5.vote_total  = (total_wide > WIDE_W'({VOTE_W{1'b1}})) ? '1
                                                                   : total_wide[VOTE_W-1:0];
        if (r_s4.st_zero) begin
            n_s5.strand = STRAND_UNSTRANDED;
        end else if (r_s4.p_fwd < r_s4.p_rev) begin
            n_s5.strand = STRAND_REVERSE;
        end else if (r_s4.p_fwd < r_s4.p_uns) begin
            n_s5.strand = STRAND_UNSTRANDED;
        end else begin
            n_s5.strand = STRAND_FORWARD;
        end
        n_s5.weak_winner       = !n_s5.no_votes && (r_s4.p_best < r_s4.p_weak);
        n_s5.winner_not_inward = (r_s4.winner == FMT_OSF) || (r_s4.winner == FMT_OSR) ||
                                 (r_s4.winner == FMT_MSF) || (r_s4.winner == FMT_MSR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_v2) begin
            r_s3 <= n_s3;
        end
        if (rdy4 && r_v3) begin
            r_s4 <= n_s4;
        end
        if (rdy5 && r_v4) begin
            r_s5 <= n_s5;
        end
    end

    a_no_votes_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && r_s5.no_votes |-> r_s5.winner == FMT_NONE && !r_s5.weak_winner &&
        !r_s5.winner_not_inward && r_s5.orient == ORIENT_INWARD &&
        r_s5.strand == STRAND_UNSTRANDED)
        else $error("decision reported with no votes counted");

    a_votes_have_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && !r_s5.no_votes |-> r_s5.winner != FMT_NONE)
        else $error("votes counted but no winner format");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && !i_ready |=> r_v5 && $stable(r_s5))
        else $error("stalled result changed or dropped");

endmodule

@@ verif/prltv_vote_checker.sv @@
// Checker for the paired read library type voter: watches the exon and result
// channels, predicts each decision and compares it field by field.
// Depends on prltv_pkg for the format, orientation, strand and register codes.
module prltv_vote_checker
    import prltv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [PCT_W-1:0]   i_cfg_wdata,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [MATE_W-1:0]  i_mate_index,
    input  logic [START_W-1:0] i_exon_start,
    input  logic               i_strand_label,
    input  logic               i_is_paired,
    input  logic               i_last_exon,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [2:0]         i_voted_format,
    input  logic [1:0]         i_pair_orientation,
    input  logic [1:0]         i_strand_call,
    input  logic [2:0]         i_winner_format,
    input  logic [VOTE_W-1:0]  i_vote_total,
    input  logic               i_no_votes,
    input  logic               i_weak_winner,
    input  logic               i_winner_not_inward,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    localparam int FIRST_CODE = int'(FMT_ISF);
    localparam int LAST_CODE = int'(FMT_IU);
    localparam logic [CW-1:0] COUNT_FULL = '1;
    localparam longint unsigned VOTE_FULL = (64'd1 << VOTE_W) - 1;

    logic [PCT_W-1:0]   rev_pct;
    logic [PCT_W-1:0]   unstr_pct;
    logic [PCT_W-1:0]   weak_pct;
    logic               seen_first;
    logic               seen_second;
    logic [START_W-1:0] left_first;
    logic [START_W-1:0] left_second;
    logic [CW-1:0]      votes [FIRST_CODE:LAST_CODE];
    logic [CW-1:0]      vote_sum;
    t_result            decision_q[$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic log_failure(input string msg);
        $display("checker: %s", msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input longint unsigned seen,
            input longint unsigned wanted);
        if (seen != wanted)
            log_failure($sformatf("%s is %0d, expected %0d", name, seen, wanted));
    endtask

    function automatic longint unsigned tally(input t_format code);
        return 64'(votes[int'(code)]);
    endfunction

    // Folds one exon into the alignment state; a last exon closes the
    // alignment, casts its vote and queues the running decision.
    function automatic void fold_exon(input logic [MATE_W-1:0] mate,
            input logic [START_W-1:0] start, input logic strand,
            input logic paired, input logic last);
        t_format         voted;
        t_format         winner;
        t_result         r;
        longint unsigned inw, outw, samew, fwd, rvs, stranded, best, total;
        if (mate == MATE_FIRST) begin
            seen_first = 1'b1;
            if (start < left_first)
                left_first = start;
        end else if (mate == MATE_SECOND) begin
            seen_second = 1'b1;
            if (start < left_second)
                left_second = start;
        end
        if (!last)
            return;

        voted = FMT_NONE;
        if (paired && seen_first && seen_second) begin
            if (!strand)
                voted = (left_first <= left_second) ? FMT_ISF : FMT_OSF;
            else
                voted = (left_second <= left_first) ? FMT_ISR : FMT_OSR;
            if (votes[int'(voted)] != COUNT_FULL)
                votes[int'(voted)] = votes[int'(voted)] + 1'b1;
            if (vote_sum != COUNT_FULL)
                vote_sum = vote_sum + 1'b1;
        end
        seen_first = 1'b0;
        seen_second = 1'b0;
        left_first = LEFT_INIT;
        left_second = LEFT_INIT;

        r.voted = voted;
        inw = tally(FMT_ISF) + tally(FMT_ISR) + tally(FMT_IU);
        outw = tally(FMT_OSF) + tally(FMT_OSR);
        samew = tally(FMT_MSF) + tally(FMT_MSR);
        if (inw >= outw && inw >= samew)
            r.orient = ORIENT_INWARD;
        else if (outw >= inw && outw >= samew)
            r.orient = ORIENT_OUTWARD;
        else
            r.orient = ORIENT_SAME;

        // Percent thresholds are compared by cross multiplication.
        fwd = tally(FMT_ISF) + tally(FMT_OSF) + tally(FMT_MSF);
        rvs = tally(FMT_ISR) + tally(FMT_OSR) + tally(FMT_MSR);
        stranded = fwd + rvs;
        r.strand = STRAND_UNSTRANDED;
        if (stranded != 0) begin
            if (fwd * 64'd100 < 64'(rev_pct) * stranded)
                r.strand = STRAND_REVERSE;
            else if (fwd * 64'd100 < 64'(unstr_pct) * stranded)
                r.strand = STRAND_UNSTRANDED;
            else
                r.strand = STRAND_FORWARD;
        end

        // Ties go to the lower code since only a strictly larger count wins.
        winner = FMT_NONE;
        best = 0;
        for (int code = FIRST_CODE; code <= LAST_CODE; code++) begin
            if (64'(votes[code]) > best) begin
                best = 64'(votes[code]);
                winner = t_format'(code);
            end
        end
        total = 64'(vote_sum);
        r.winner = winner;
        r.vote_total = VOTE_W'((total > VOTE_FULL) ? VOTE_FULL : total);
        r.no_votes = (total == 0);
        r.weak_winner = (total != 0) && (best * 64'd100 < 64'(weak_pct) * total);
        r.winner_not_inward = winner inside {FMT_OSF, FMT_OSR, FMT_MSF, FMT_MSR};
        decision_q.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            rev_pct = RESET_REVERSE_PCT;
            unstr_pct = RESET_UNSTRANDED_PCT;
            weak_pct = RESET_WEAK_PCT;
            seen_first = 1'b0;
            seen_second = 1'b0;
            left_first = LEFT_INIT;
            left_second = LEFT_INIT;
            for (int c = FIRST_CODE; c <= LAST_CODE; c++)
                votes[c] = '0;
            vote_sum = '0;
            decision_q.delete();
        end else begin
            // Results are checked before this edge's exon is folded in; a
            // result can never belong to an exon accepted at the same edge.
            if (i_rsp_valid && i_rsp_ready) begin
                if (decision_q.size() == 0) begin
                    log_failure("result with no closed alignment waiting");
                end else begin
                    want = decision_q.pop_front();
                    seen.voted = t_format'(i_voted_format);
                    seen.orient = t_orient'(i_pair_orientation);
                    seen.strand = t_strand'(i_strand_call);
                    seen.winner = t_format'(i_winner_format);
                    seen.vote_total = i_vote_total;
                    seen.no_votes = i_no_votes;
                    seen.weak_winner = i_weak_winner;
                    seen.winner_not_inward = i_winner_not_inward;
                    check_field("voted_format", seen.voted, want.voted);
                    check_field("pair_orientation", seen.orient, want.orient);
                    check_field("strand_call", seen.strand, want.strand);
                    check_field("winner_format", seen.winner, want.winner);
                    check_field("vote_total", seen.vote_total, want.vote_total);
                    check_field("no_votes", seen.no_votes, want.no_votes);
                    check_field("weak_winner", seen.weak_winner, want.weak_winner);
                    check_field("winner_not_inward", seen.winner_not_inward,
                                want.winner_not_inward);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REVERSE_PCT:    rev_pct = i_cfg_wdata;
                    CFG_UNSTRANDED_PCT: unstr_pct = i_cfg_wdata;
                    CFG_WEAK_PCT:       weak_pct = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                fold_exon(i_mate_index, i_exon_start, i_strand_label, i_is_paired,
                          i_last_exon);
        end
        o_outstanding <= decision_q.size();
    end

endmodule

@@ verif/tb_paired_read_library_type_voter.sv @@
// Testbench top for the paired read library type voter: drives exon requests,
// threshold writes and result back-pressure, and gives the final verdict.
// Depends on prltv_pkg, the voter RTL and prltv_vote_checker.
module tb_paired_read_library_type_voter;
    import prltv_pkg::*;

    // The cycle limit leaves a wide margin over a correct run for receiver
    // stalls and sender gaps.
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 720;
    localparam int DIRECTED_ITEMS = 22;
    localparam int NUM_PHASES = 6;
    // The pipeline holds six registers; this covers a non-last exon still in
    // flight when the last expected result has come.
    localparam int SETTLE_CYCLES = 12;
    localparam logic [START_W-1:0] START_MAX = '1;
    localparam logic [MATE_W-1:0] MATE_IGNORED_LO = 2'd2;
    localparam logic [MATE_W-1:0] MATE_IGNORED_HI = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_BLOCK
    } t_stall;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = CFG_REVERSE_PCT;
    logic [PCT_W-1:0]   cfg_wdata = '0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [MATE_W-1:0]  mate_index = MATE_FIRST;
    logic [START_W-1:0] exon_start = '0;
    logic [15:0]        exon_length = '0;
    logic               strand_label = 1'b0;
    logic               is_paired = 1'b0;
    logic               last_exon = 1'b0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b1;
    logic [2:0]         voted_format;
    logic [1:0]         pair_orientation;
    logic [1:0]         strand_call;
    logic [2:0]         winner_format;
    logic [VOTE_W-1:0]  vote_total;
    logic               no_votes;
    logic               weak_winner;
    logic               winner_not_inward;
    int                 fail_count;
    int                 outstanding;

    int unsigned        cycle_count = 0;
    int                 burst_left = 0;
    int                 items_sent = 0;
    t_stall             stall_mode = STALL_NONE;
    int                 stall_left = 0;

    always #10 clk = ~clk;

    paired_read_library_type_voter dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_wdata            (cfg_wdata),
        .i_valid                (req_valid),
        .o_ready                (req_ready),
        .i_mate_index           (mate_index),
        .i_exon_start           (exon_start),
        .i_exon_length          (exon_length),
        .i_strand_label         (strand_label),
        .i_is_paired            (is_paired),
        .i_last_exon            (last_exon),
        .o_valid                (rsp_valid),
        .i_ready                (rsp_ready),
        .o_voted_format         (voted_format),
        .o_pair_orientation     (pair_orientation),
        .o_strand_call          (strand_call),
        .o_winner_format        (winner_format),
        .o_vote_total           (vote_total),
        .o_no_votes             (no_votes),
        .o_weak_winner          (weak_winner),
        .o_winner_not_inward    (winner_not_inward)
    );

    prltv_vote_checker u_vote_check (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_wdata            (cfg_wdata),
        .i_req_valid            (req_valid),
        .i_req_ready            (req_ready),
        .i_mate_index           (mate_index),
        .i_exon_start           (exon_start),
        .i_strand_label         (strand_label),
        .i_is_paired            (is_paired),
        .i_last_exon            (last_exon),
        .i_rsp_valid            (rsp_valid),
        .i_rsp_ready            (rsp_ready),
        .i_voted_format         (voted_format),
        .i_pair_orientation     (pair_orientation),
        .i_strand_call          (strand_call),
        .i_winner_format        (winner_format),
        .i_vote_total           (vote_total),
        .i_no_votes             (no_votes),
        .i_weak_winner          (weak_winner),
        .i_winner_not_inward    (winner_not_inward),
        .o_fail_count           (fail_count),
        .o_outstanding          (outstanding)
    );

    // Cycle counter and watchdog. A hung handshake ends the run here.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Result back-pressure. The receiver switches between a few stall styles
    // for random stretches: always ready, coin flips, mostly stalled, and a
    // short ready window that recurs regularly.
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:   rsp_ready = 1'b1;
            STALL_COIN:   rsp_ready = 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_ready = ($urandom_range(0, 3) == 0);
            default:      rsp_ready = ((stall_left % 16) < 3);
        endcase
    end

    // Sends one exon request. The sender runs in bursts; when a burst is used
    // up, valid may drop for a random gap before the next one starts. Valid
    // stays high after acceptance until the next falling edge, where it is
    // either loaded with the next request or lowered.
    task automatic send_exon(input logic [MATE_W-1:0] mate,
            input logic [START_W-1:0] start, input logic [15:0] len,
            input logic strand, input logic paired, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                req_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        mate_index = mate;
        exon_start = start;
        exon_length = len;
        strand_label = strand;
        is_paired = paired;
        last_exon = last;
        req_valid = 1'b1;
        do @(posedge clk); while (!req_ready);
        burst_left--;
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has come back,
    // then lets the pipeline run empty behind any trailing non-last exon.
    task automatic drain_and_settle();
        @(negedge clk);
        req_valid = 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input t_cfg_index idx, input logic [PCT_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // A later exon of a mate that already has its leftmost start placed,
    // clamped so it never wraps past the top coordinate.
    function automatic logic [START_W-1:0] later_start(input logic [START_W-1:0] left);
        logic [31:0] sum;
        sum = 32'(left) + $urandom_range(0, 5000);
        return (sum > 32'(START_MAX)) ? START_MAX : START_W'(sum);
    endfunction

    // Sends one alignment. Most are well-formed paired alignments whose mate
    // order is chosen so that the vote lands on the intended orientation;
    // some are broken (unpaired or a mate missing), and a few are single
    // noise exons with every field random. Ignored mate indexes are mixed in
    // now and then, and any exon may be the one that closes the alignment.
    task automatic send_alignment(input int strand_pct, input int outward_pct);
        logic [MATE_W-1:0]  mates[$];
        logic [MATE_W-1:0]  swap;
        logic [START_W-1:0] lo, hi, left0, left1, start;
        logic               strand, outward, paired, placed0, placed1;
        int                 kind, n0, n1, nx, pick;
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            send_exon(MATE_W'($urandom_range(0, 3)), START_W'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            return;
        end
        n0 = $urandom_range(1, 2);
        n1 = $urandom_range(1, 2);
        nx = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        paired = 1'b1;
        if (kind >= 80) begin
            case ($urandom_range(0, 2))
                0:       paired = 1'b0;
                1:       n0 = 0;
                default: n1 = 0;
            endcase
        end
        strand = ($urandom_range(0, 99) < strand_pct);
        outward = ($urandom_range(0, 99) < outward_pct);

        // The forward mate sits at lo for an inward pair and at hi for an
        // outward one; equal starts count as inward.
        lo = ($urandom_range(0, 3) == 0) ? START_W'($urandom_range(0, 64))
                                         : START_W'($urandom_range(0, 32'h7FFF_E000));
        hi = (!outward && $urandom_range(0, 7) == 0) ? lo
                                                     : lo + START_W'($urandom_range(1, 4000));
        left0 = (outward ^ strand) ? hi : lo;
        left1 = (outward ^ strand) ? lo : hi;

        for (int j = 0; j < n0; j++)
            mates.push_back(MATE_FIRST);
        for (int j = 0; j < n1; j++)
            mates.push_back(MATE_SECOND);
        for (int j = 0; j < nx; j++)
            mates.push_back($urandom_range(0, 1) ? MATE_IGNORED_HI : MATE_IGNORED_LO);
        for (int j = mates.size() - 1; j > 0; j--) begin
            pick = $urandom_range(0, j);
            swap = mates[j];
            mates[j] = mates[pick];
            mates[pick] = swap;
        end

        placed0 = 1'b0;
        placed1 = 1'b0;
        for (int j = 0; j < mates.size(); j++) begin
            if (mates[j] == MATE_FIRST) begin
                start = placed0 ? later_start(left0) : left0;
                placed0 = 1'b1;
            end else if (mates[j] == MATE_SECOND) begin
                start = placed1 ? later_start(left1) : left1;
                placed1 = 1'b1;
            end else begin
                start = START_W'($urandom);
            end
            send_exon(mates[j], start, 16'($urandom), strand, paired,
                      j == mates.size() - 1);
        end
    endtask

    initial begin
        int phase_end;
        int strand_pct;
        int outward_pct;

        // Reset is held from time zero and released on a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, run with the reset thresholds.
        // An ignored mate closing an empty alignment: no vote, no votes yet.
        send_exon(MATE_IGNORED_HI, START_MAX, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // Inward, mate one forward, closed by mate two.
        send_exon(MATE_FIRST, 31'd100, 16'h0000, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_SECOND, 31'd200, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        // Equal starts at zero count as inward.
        send_exon(MATE_SECOND, '0, 16'h0000, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_FIRST, '0, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        // Outward with mate one forward, starting at the top coordinate.
        send_exon(MATE_FIRST, START_MAX, 16'h0001, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_SECOND, 31'd5, 16'h8000, 1'b0, 1'b1, 1'b1);
        // Mate two forward, both at the top coordinate: inward on the tie.
        send_exon(MATE_FIRST, START_MAX, 16'h7FFF, 1'b1, 1'b1, 1'b0);
        send_exon(MATE_SECOND, START_MAX, 16'h0000, 1'b1, 1'b1, 1'b1);
        // Outward with mate two forward.
        send_exon(MATE_SECOND, 31'd500, 16'h1234, 1'b1, 1'b1, 1'b0);
        send_exon(MATE_FIRST, 31'd1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // Both mates present but the alignment is not paired.
        send_exon(MATE_FIRST, 31'd10, 16'h00FF, 1'b0, 1'b0, 1'b0);
        send_exon(MATE_SECOND, 31'd20, 16'hFF00, 1'b0, 1'b0, 1'b1);
        // Paired, but mate two never shows up.
        send_exon(MATE_FIRST, 31'd10, 16'h0F0F, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_FIRST, 31'd5, 16'hF0F0, 1'b0, 1'b1, 1'b1);
        // Several exons per mate with ignored mates in between; the leftmost
        // start of mate one is 50, so the pair is inward. An ignored mate
        // carries the last mark.
        send_exon(MATE_FIRST, 31'd300, 16'h0010, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_SECOND, 31'd150, 16'h0020, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_FIRST, 31'd50, 16'h0030, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_IGNORED_LO, '0, 16'h0040, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_FIRST, 31'd400, 16'h0050, 1'b0, 1'b1, 1'b0);
        send_exon(MATE_IGNORED_HI, '0, 16'h0060, 1'b0, 1'b1, 1'b1);
        // A lone mate two right after: the previous close must have cleared
        // mate one, so this casts no vote.
        send_exon(MATE_SECOND, 31'd7, 16'h0070, 1'b0, 1'b1, 1'b1);

        // Random part in phases. Each phase after the first drains the block,
        // rewrites the thresholds while idle and shifts the strand and
        // orientation mix so the running decision crosses its boundaries.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            strand_pct = 50;
            outward_pct = 90;
            if (phase > 0)
                drain_and_settle();
            case (phase)
                1: begin
                    write_threshold(CFG_REVERSE_PCT, 7'd0);
                    write_threshold(CFG_UNSTRANDED_PCT, 7'd0);
                    write_threshold(CFG_WEAK_PCT, 7'd0);
                    strand_pct = 90;
                    outward_pct = 10;
                end
                2: begin
                    write_threshold(CFG_REVERSE_PCT, 7'd127);
                    write_threshold(CFG_UNSTRANDED_PCT, 7'd127);
                    write_threshold(CFG_WEAK_PCT, 7'd127);
                    strand_pct = 10;
                    outward_pct = 50;
                end
                3: begin
                    write_threshold(CFG_REVERSE_PCT, 7'd100);
                    write_threshold(CFG_UNSTRANDED_PCT, 7'd100);
                    write_threshold(CFG_WEAK_PCT, 7'd100);
                    strand_pct = 50;
                    outward_pct = 30;
                end
                4: begin
                    write_threshold(CFG_REVERSE_PCT, PCT_W'($urandom_range(0, 100)));
                    write_threshold(CFG_UNSTRANDED_PCT, PCT_W'($urandom_range(0, 100)));
                    write_threshold(CFG_WEAK_PCT, PCT_W'($urandom_range(0, 100)));
                    strand_pct = $urandom_range(0, 100);
                    outward_pct = $urandom_range(0, 100);
                end
                5: begin
                    write_threshold(CFG_REVERSE_PCT, RESET_REVERSE_PCT);
                    write_threshold(CFG_UNSTRANDED_PCT, RESET_UNSTRANDED_PCT);
                    write_threshold(CFG_WEAK_PCT, RESET_WEAK_PCT);
                    strand_pct = 30;
                    outward_pct = 20;
                end
                default: ;
            endcase
            phase_end = DIRECTED_ITEMS
                      + (ITEM_TARGET - DIRECTED_ITEMS) * (phase + 1) / NUM_PHASES;
            while (items_sent < phase_end)
                send_alignment(strand_pct, outward_pct);
        end

        // Wind down: wait for every result, then a few more cycles so that
        // any stray extra result would still be caught by the checker.
        drain_and_settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/prltv_pkg.sv
rtl/core/prltv_tally.sv
rtl/core/prltv_decide.sv
rtl/core/paired_read_library_type_voter.sv
verif/prltv_vote_checker.sv
verif/tb_paired_read_library_type_voter.sv
